@@ rtl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the steering torque split
// Payload structs, configuration bundle, controller commands and the slew
// helper used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  // Q1.15 unity
  localparam logic [15:0] UNITY = 16'h8000;

  // Request payload
  typedef struct packed {
    logic signed [15:0] steering_angle;
    logic signed [15:0] driver_torque;
  } sts_in_t;

  // Result payload
  typedef struct packed {
    logic signed [15:0] left_torque;
    logic signed [15:0] right_torque;
    logic [15:0]        shared_mult_out;
    logic [15:0]        left_mult_out;
    logic [15:0]        right_mult_out;
  } sts_out_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SDIFF_ENABLE  = 3'd0,
    CFG_RACK_GAIN     = 3'd1,
    CFG_NORM_GAIN     = 3'd2,
    CFG_DEADBAND      = 3'd3,
    CFG_K_INNER       = 3'd4,
    CFG_SHARED_DERATE = 3'd5,
    CFG_F_MIN         = 3'd6,
    CFG_SLEW_STEP     = 3'd7
  } cfg_index_t;

  // Configuration bundle
  typedef struct packed {
    logic        sdiff_enable;
    logic [15:0] rack_gain;
    logic [15:0] norm_gain;
    logic [14:0] deadband;
    logic [15:0] k_inner;
    logic [15:0] shared_derate;
    logic [15:0] f_min;
    logic [15:0] slew_step;
  } cfg_regs_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RACK,
    ST_RACK_WB,
    ST_NORM,
    ST_NORM_WB,
    ST_DERATE,
    ST_INNER,
    ST_INNER_WB,
    ST_SLEW,
    ST_PROD_L,
    ST_PROD_R,
    ST_PROD_WB,
    ST_TQ_L,
    ST_TQ_R,
    ST_TQ_WB,
    ST_FINISH
  } ctl_state_t;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RACK,
    MUL_NORM,
    MUL_DERATE,
    MUL_INNER,
    MUL_LEFT,
    MUL_RIGHT,
    MUL_TQ_L,
    MUL_TQ_R
  } mul_sel_t;

  // Product write-back destination
  typedef enum logic [3:0] {
    WB_NONE,
    WB_RACK,
    WB_NORM,
    WB_SHARED_TGT,
    WB_INNER,
    WB_PL,
    WB_PR,
    WB_TQ_L,
    WB_TQ_R
  } wb_sel_t;

  // Controller to datapath
  typedef struct packed {
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     load_in;
    logic     slew;
    logic     load_out;
  } sts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_stat_t;

  // Move cur toward tgt by at most step
  function automatic logic [15:0] move_toward(input logic [15:0] cur,
                                              input logic [15:0] tgt,
                                              input logic [15:0] step);
    logic [15:0] up;
    logic [15:0] dn;
    up = tgt - cur;
    dn = cur - tgt;
    if (tgt > cur) begin
      return (up > step) ? cur + step : tgt;
    end else if (tgt < cur) begin
      return (dn > step) ? cur - step : tgt;
    end
    return cur;
  endfunction

endpackage

`default_nettype wire

@@ rtl/steering_torque_split.sv @@
// ----------------------------------------------------------------------------
// steering_torque_split: steering-dependent torque split for two hub motors
// Top level: configuration registers, sequencing controller and datapath.
// ----------------------------------------------------------------------------
// Each request (steering angle, driver torque) goes from acceptance to its
// result being loaded into the output register as follows: the eight
// products of the calculation all run, one after another, through a single
// registered 17x16 multiplier, with a write-back state after each dependent
// product and a slew update state. A new request is taken only once the
// previous result is loaded; the finished result sits in its own output
// register, so the next request is accepted and worked on while the previous
// result waits to be taken. Configuration writes land at once and must only
// be made while no request is in progress.
`default_nettype none

module steering_torque_split (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sts_pkg::sts_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sts_pkg::sts_out_t     out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  import sts_pkg::*;

  cfg_regs_t cfg;
  sts_cmd_t  cmd;
  sts_stat_t stat;

  // Configuration registers
  sts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Controller
  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  sts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/sts_cfg.sv @@
// ----------------------------------------------------------------------------
// sts_cfg: configuration register file
// Eight write-only registers, loaded by index from the write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output sts_pkg::cfg_regs_t     cfg
);
  import sts_pkg::*;

  // Register writes, reset to the tuned defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sdiff_enable  <= 1'b0;
      cfg.rack_gain     <= 16'd12136;
      cfg.norm_gain     <= 16'd32768;
      cfg.deadband      <= 15'd128;
      cfg.k_inner       <= 16'd13763;
      cfg.shared_derate <= 16'd0;
      cfg.f_min         <= 16'd16384;
      cfg.slew_step     <= 16'd328;
    end else if (cfg_wr_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SDIFF_ENABLE:  cfg.sdiff_enable  <= cfg_data[0];
        CFG_RACK_GAIN:     cfg.rack_gain     <= cfg_data;
        CFG_NORM_GAIN:     cfg.norm_gain     <= cfg_data;
        CFG_DEADBAND:      cfg.deadband      <= cfg_data[14:0];
        CFG_K_INNER:       cfg.k_inner       <= cfg_data;
        CFG_SHARED_DERATE: cfg.shared_derate <= cfg_data;
        CFG_F_MIN:         cfg.f_min         <= cfg_data;
        CFG_SLEW_STEP:     cfg.slew_step     <= cfg_data;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sts_ctrl.sv @@
// ----------------------------------------------------------------------------
// sts_ctrl: sequencing controller
// Walks one request through the shared multiplier, the slew update and the
// hand-over to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sts_pkg::sts_stat_t stat,
  output sts_pkg::sts_cmd_t      cmd
);
  import sts_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.mul_sel  = MUL_NONE;
    cmd.wb_sel   = WB_NONE;
    cmd.load_in  = 1'b0;
    cmd.slew     = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_RACK;
        end
      end
      ST_RACK: begin
        cmd.mul_sel = MUL_RACK;
        state_next  = ST_RACK_WB;
      end
      ST_RACK_WB: begin
        cmd.wb_sel = WB_RACK;
        state_next = ST_NORM;
      end
      ST_NORM: begin
        cmd.mul_sel = MUL_NORM;
        state_next  = ST_NORM_WB;
      end
      ST_NORM_WB: begin
        cmd.wb_sel = WB_NORM;
        state_next = ST_DERATE;
      end
      ST_DERATE: begin
        cmd.mul_sel = MUL_DERATE;
        state_next  = ST_INNER;
      end
      ST_INNER: begin
        cmd.mul_sel = MUL_INNER;
        cmd.wb_sel  = WB_SHARED_TGT;
        state_next  = ST_INNER_WB;
      end
      ST_INNER_WB: begin
        cmd.wb_sel = WB_INNER;
        state_next = ST_SLEW;
      end
      ST_SLEW: begin
        cmd.slew   = 1'b1;
        state_next = ST_PROD_L;
      end
      ST_PROD_L: begin
        cmd.mul_sel = MUL_LEFT;
        state_next  = ST_PROD_R;
      end
      ST_PROD_R: begin
        cmd.mul_sel = MUL_RIGHT;
        cmd.wb_sel  = WB_PL;
        state_next  = ST_PROD_WB;
      end
      ST_PROD_WB: begin
        cmd.wb_sel = WB_PR;
        state_next = ST_TQ_L;
      end
      ST_TQ_L: begin
        cmd.mul_sel = MUL_TQ_L;
        state_next  = ST_TQ_R;
      end
      ST_TQ_R: begin
        cmd.mul_sel = MUL_TQ_R;
        cmd.wb_sel  = WB_TQ_L;
        state_next  = ST_TQ_WB;
      end
      ST_TQ_WB: begin
        cmd.wb_sel = WB_TQ_R;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the result register to free up
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sts_dp.sv @@
// ----------------------------------------------------------------------------
// sts_dp: kept multipliers
// Shared, left and right Q1.15 multipliers, each stepped toward its target
// by at most the slew step when the update is commanded.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_dp (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        slew,
  input  wire logic [15:0] step,
  input  wire logic [15:0] sh_t,
  input  wire logic [15:0] l_t,
  input  wire logic [15:0] r_t,
  output logic [15:0]      shared_mult,
  output logic [15:0]      left_mult,
  output logic [15:0]      right_mult
);
  import sts_pkg::*;

  // Slew update, unity out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_mult <= UNITY;
      left_mult   <= UNITY;
      right_mult  <= UNITY;
    end else if (slew) begin
      shared_mult <= move_toward(shared_mult, sh_t, step);
      left_mult   <= move_toward(left_mult, l_t, step);
      right_mult  <= move_toward(right_mult, r_t, step);
    end
  end

endmodule

`default_nettype wire

@@ rtl/sts_datapath.sv @@
// ----------------------------------------------------------------------------
// sts_datapath: arithmetic datapath
// One registered 17x16 multiplier shared by all eight products, the kept
// multipliers with their slew update, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sts_pkg::sts_cmd_t  cmd,
  output sts_pkg::sts_stat_t      stat,
  input  wire sts_pkg::cfg_regs_t cfg,
  input  wire sts_pkg::sts_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sts_pkg::sts_out_t       out_data
);
  import sts_pkg::*;

  // Latched request
  logic        ang_neg;
  logic        ang_nz;
  logic [16:0] ang_mag;
  logic        tq_neg;
  logic [16:0] tq_mag;

  // Working values
  logic [31:0] prod;
  logic [14:0] rack_mag;
  logic [15:0] norm;
  logic [15:0] f_tgt;
  logic [15:0] g_in;
  logic [15:0] pl;
  logic [15:0] pr;
  logic [15:0] tq_l;
  logic [15:0] tq_r;

  // Kept multipliers
  logic [15:0] shared_mult;
  logic [15:0] left_mult;
  logic [15:0] right_mult;

  // Operands and post-processed products
  logic [16:0] op_a;
  logic [15:0] op_b;
  logic [22:0] norm_raw;
  logic [15:0] norm_w;
  logic [15:0] dr;
  logic signed [17:0] f_diff;
  logic [15:0] f_w;
  logic [15:0] g_w;
  logic [16:0] p_raw;
  logic [15:0] p_w;
  logic [15:0] tq_w;

  // Turn decision and targets
  logic        turn;
  logic [15:0] sh_t;
  logic [15:0] in_t;
  logic [15:0] l_t;
  logic [15:0] r_t;

  assign stat.out_busy = out_valid && !out_ready;

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RACK:   begin op_a = ang_mag;              op_b = cfg.rack_gain;     end
      MUL_NORM:   begin op_a = {2'b00, rack_mag};    op_b = cfg.norm_gain;     end
      MUL_DERATE: begin op_a = {1'b0, norm};         op_b = cfg.shared_derate; end
      MUL_INNER:  begin op_a = {1'b0, norm};         op_b = cfg.k_inner;       end
      MUL_LEFT:   begin op_a = {1'b0, shared_mult};  op_b = left_mult;         end
      MUL_RIGHT:  begin op_a = {1'b0, shared_mult};  op_b = right_mult;        end
      MUL_TQ_L:   begin op_a = tq_mag;               op_b = pl;                end
      MUL_TQ_R:   begin op_a = tq_mag;               op_b = pr;                end
      default:    begin op_a = '0;                   op_b = '0;                end
    endcase
  end

  // Post-processing of the registered product
  always_comb begin
    norm_raw = prod[30:8];
    norm_w   = (norm_raw > 23'd32768) ? UNITY : norm_raw[15:0];
    dr       = prod[30:15];
    f_diff   = $signed({2'b00, UNITY}) - $signed({2'b00, dr});
    f_w      = (f_diff < $signed({2'b00, cfg.f_min})) ? cfg.f_min : f_diff[15:0];
    g_w      = (dr > UNITY) ? 16'd0 : UNITY - dr;
    p_raw    = prod[31:15];
    p_w      = (p_raw > {1'b0, UNITY}) ? UNITY : p_raw[15:0];
    tq_w     = prod[30:15];
  end

  // Slew targets
  always_comb begin
    turn = ang_nz && (rack_mag > cfg.deadband);
    sh_t = cfg.sdiff_enable ? f_tgt : UNITY;
    in_t = cfg.sdiff_enable ? g_in : UNITY;
    l_t  = (turn && !ang_neg) ? in_t : UNITY;
    r_t  = (turn && ang_neg) ? in_t : UNITY;
  end

  // Request latch, multiplier and write-back
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ang_neg <= in_data.steering_angle[15];
      ang_nz  <= (in_data.steering_angle != 16'sd0);
      ang_mag <= in_data.steering_angle[15]
                 ? 17'h10000 - {1'b0, in_data.steering_angle}
                 : {1'b0, in_data.steering_angle};
      tq_neg  <= in_data.driver_torque[15];
      tq_mag  <= in_data.driver_torque[15]
                 ? 17'h10000 - {1'b0, in_data.driver_torque}
                 : {1'b0, in_data.driver_torque};
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= 32'(op_a) * 32'(op_b);
    end
    unique case (cmd.wb_sel)
      WB_RACK:       rack_mag <= prod[30:16];
      WB_NORM:       norm     <= norm_w;
      WB_SHARED_TGT: f_tgt    <= f_w;
      WB_INNER:      g_in     <= g_w;
      WB_PL:         pl       <= p_w;
      WB_PR:         pr       <= p_w;
      WB_TQ_L:       tq_l     <= tq_neg ? 16'd0 - tq_w : tq_w;
      WB_TQ_R:       tq_r     <= tq_neg ? 16'd0 - tq_w : tq_w;
      default:       ;
    endcase
  end

  // Kept multipliers
  sts_dp u_slew (
    .clk         (clk),
    .rst         (rst),
    .slew        (cmd.slew),
    .step        (cfg.slew_step),
    .sh_t        (sh_t),
    .l_t         (l_t),
    .r_t         (r_t),
    .shared_mult (shared_mult),
    .left_mult   (left_mult),
    .right_mult  (right_mult)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.left_torque     <= tq_l;
      out_data.right_torque    <= tq_r;
      out_data.shared_mult_out <= shared_mult;
      out_data.left_mult_out   <= left_mult;
      out_data.right_mult_out  <= right_mult;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sts_checker.sv @@
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the steering torque split
// Watches the top level's ports over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sts_pkg::sts_out_t out_data
);
  import sts_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One request at a time: busy after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in work");

  // Side gains never exceed unity
  a_side_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.left_mult_out <= UNITY) &&
                  (out_data.right_mult_out <= UNITY))
    else $error("side gain above unity");

  // No result straight out of reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind steering_torque_split sts_checker u_sts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the steering torque split
// Drives steering/torque requests over valid/ready with bursty pacing, stalls
// the result side on its own pattern, and compares each result field by field
// with a cycle-free prediction of the split, slew state included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import sts_pkg::*;

  localparam int  STALL_LIMIT     = 3000;
  localparam int  DRAIN_CYCLES    = 24;
  localparam int  RANDOM_PHASES   = 10;
  localparam int  ITEMS_PER_PHASE = 88;
  localparam int  MAX_REPORTS     = 10;
  localparam longint ONE_Q15      = 32768;

  // Full register image, indexed by register name
  typedef logic [CFG_SLEW_STEP:0][15:0] reg_set_t;

  // Result-side stall patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sts_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sts_out_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predicted register copy and kept multipliers
  cfg_regs_t   split_cfg;
  logic [15:0] shared_m;
  logic [15:0] left_m;
  logic [15:0] right_m;

  sts_out_t expected_splits[$];

  int mismatches    = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int phases_run    = 0;
  int left_turns    = 0;
  int right_turns   = 0;
  int straights     = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  rx_mode_t rx_mode  = RX_ALWAYS;
  int       rx_left  = 0;
  int       rx_count = 0;

  steering_torque_split dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One tick of slew toward a target, bounded by the configured step
  function automatic logic [15:0] slew_toward(input logic [15:0] cur,
                                              input logic [15:0] tgt);
    int diff;
    int step;
    int nxt;
    diff = int'(tgt) - int'(cur);
    step = int'(split_cfg.slew_step);
    if (diff > step) begin
      nxt = int'(cur) + step;
      return nxt[15:0];
    end
    if (diff < -step) begin
      nxt = int'(cur) - step;
      return nxt[15:0];
    end
    return tgt;
  endfunction

  // Torque times Q1.15 factor, truncated toward zero
  function automatic logic signed [15:0] scale_torque(input logic signed [15:0] t,
                                                      input longint mult);
    longint v;
    longint m;
    v = t;
    m = (v < 0) ? -v : v;
    m = (m * mult) >> 15;
    if (v < 0) begin
      m = -m;
    end
    return m[15:0];
  endfunction

  task automatic predict_split(input sts_in_t req, output sts_out_t res);
    longint ang, mag, rack_mag, nrm, f, g, pl, pr;
    longint c_rack, c_norm, c_dead, c_kin, c_kder, c_fmin;
    logic [15:0] f_tgt, g_in, l_tgt, r_tgt;
    c_rack = split_cfg.rack_gain;
    c_norm = split_cfg.norm_gain;
    c_dead = split_cfg.deadband;
    c_kin  = split_cfg.k_inner;
    c_kder = split_cfg.shared_derate;
    c_fmin = split_cfg.f_min;

    ang = req.steering_angle;
    mag = (ang < 0) ? -ang : ang;
    rack_mag = (mag * c_rack) >> 16;
    nrm = (rack_mag * c_norm) >> 8;
    if (nrm > ONE_Q15) begin
      nrm = ONE_Q15;
    end

    // shared target clamped to [f_min, 1]; floor wins when above unity
    f = ONE_Q15 - ((c_kder * nrm) >> 15);
    if (f < c_fmin) begin
      f = c_fmin;
    end else if (f > ONE_Q15) begin
      f = ONE_Q15;
    end
    g = ONE_Q15 - ((c_kin * nrm) >> 15);
    if (g < 0) begin
      g = 0;
    end
    f_tgt = f[15:0];
    g_in  = g[15:0];
    if (!split_cfg.sdiff_enable) begin
      f_tgt = UNITY;
      g_in  = UNITY;
    end

    // inner wheel side, straight inside the deadband
    l_tgt = UNITY;
    r_tgt = UNITY;
    if (ang != 0 && rack_mag > c_dead) begin
      if (ang < 0) begin
        r_tgt = g_in;
        right_turns++;
      end else begin
        l_tgt = g_in;
        left_turns++;
      end
    end else begin
      straights++;
    end

    shared_m = slew_toward(shared_m, f_tgt);
    left_m   = slew_toward(left_m, l_tgt);
    right_m  = slew_toward(right_m, r_tgt);

    pl = (longint'(shared_m) * longint'(left_m)) >> 15;
    pr = (longint'(shared_m) * longint'(right_m)) >> 15;
    if (pl > ONE_Q15) begin
      pl = ONE_Q15;
    end
    if (pr > ONE_Q15) begin
      pr = ONE_Q15;
    end

    res.left_torque     = scale_torque(req.driver_torque, pl);
    res.right_torque    = scale_torque(req.driver_torque, pr);
    res.shared_mult_out = shared_m;
    res.left_mult_out   = left_m;
    res.right_mult_out  = right_m;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Hold the request until taken, then predict its result
  task automatic send_request(input sts_in_t req);
    sts_out_t res;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_split(req, res);
    expected_splits.push_back(res);
    requests_sent++;
  endtask

  // Bursts of requests with random gaps between them
  task automatic send_paced(input sts_in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_request(req);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SDIFF_ENABLE:  split_cfg.sdiff_enable  = val[0];
      CFG_RACK_GAIN:     split_cfg.rack_gain     = val;
      CFG_NORM_GAIN:     split_cfg.norm_gain     = val;
      CFG_DEADBAND:      split_cfg.deadband      = val[14:0];
      CFG_K_INNER:       split_cfg.k_inner       = val;
      CFG_SHARED_DERATE: split_cfg.shared_derate = val;
      CFG_F_MIN:         split_cfg.f_min         = val;
      CFG_SLEW_STEP:     split_cfg.slew_step     = val;
      default: ;
    endcase
  endtask

  // Writes every register; caller has drained the block
  task automatic apply_config(input reg_set_t regs);
    for (int i = CFG_SDIFF_ENABLE; i <= CFG_SLEW_STEP; i++) begin
      write_reg(cfg_index_t'(i), regs[i]);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    phases_run++;
  endtask

  function automatic reg_set_t reset_regs();
    reg_set_t regs;
    regs[CFG_SDIFF_ENABLE]  = 16'd0;
    regs[CFG_RACK_GAIN]     = 16'd12136;
    regs[CFG_NORM_GAIN]     = 16'd32768;
    regs[CFG_DEADBAND]      = 16'd128;
    regs[CFG_K_INNER]       = 16'd13763;
    regs[CFG_SHARED_DERATE] = 16'd0;
    regs[CFG_F_MIN]         = 16'd16384;
    regs[CFG_SLEW_STEP]     = 16'd328;
    return regs;
  endfunction

  // Register value biased toward the edges
  function automatic logic [15:0] pick_reg(input logic [15:0] nominal,
                                           input int spread);
    case ($urandom_range(0, 6))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return UNITY;
      3, 4:    return nominal;
      default: return 16'($urandom_range(0, spread));
    endcase
  endfunction

  function automatic sts_in_t make_req(input int angle, input int torque);
    sts_in_t req;
    req.steering_angle = angle[15:0];
    req.driver_torque  = torque[15:0];
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset: derate off, torques pass through unchanged
  task automatic test_reset_passthrough();
    send_paced(make_req(0, 32767));
    send_paced(make_req(32767, -32768));
    send_paced(make_req(-32768, -1));
    send_paced(make_req(1, 1));
    drain_results();
  endtask

  // Left, right, deadband and zero angle with an instant slew
  task automatic test_turn_directions();
    reg_set_t regs;
    regs = reset_regs();
    regs[CFG_SDIFF_ENABLE]  = 16'd1;
    regs[CFG_RACK_GAIN]     = 16'd65535;
    regs[CFG_NORM_GAIN]     = 16'd256;
    regs[CFG_DEADBAND]      = 16'd100;
    regs[CFG_K_INNER]       = 16'd32768;
    regs[CFG_SHARED_DERATE] = 16'd32768;
    regs[CFG_F_MIN]         = 16'd0;
    regs[CFG_SLEW_STEP]     = 16'd32768;
    apply_config(regs);
    send_paced(make_req(16384, 32767));
    send_paced(make_req(-16384, -32768));
    send_paced(make_req(50, 20000));
    send_paced(make_req(0, -20000));
    send_paced(make_req(32767, -1));
    send_paced(make_req(-32768, 1));
    send_paced(make_req(-32768, 0));
    drain_results();
  endtask

  // Inner gain below zero, floor above unity, zero slew, disabled mid-turn
  task automatic test_limit_cases();
    reg_set_t regs;
    regs = reset_regs();
    regs[CFG_SDIFF_ENABLE]  = 16'd1;
    regs[CFG_RACK_GAIN]     = 16'd65535;
    regs[CFG_NORM_GAIN]     = 16'd65535;
    regs[CFG_DEADBAND]      = 16'd0;
    regs[CFG_K_INNER]       = 16'd65535;
    regs[CFG_SHARED_DERATE] = 16'd0;
    regs[CFG_F_MIN]         = 16'd65535;
    regs[CFG_SLEW_STEP]     = 16'd40000;
    apply_config(regs);
    send_paced(make_req(20000, 12345));
    send_paced(make_req(-20000, -32768));
    send_paced(make_req(5, 32767));
    drain_results();

    // multipliers must hold with a zero step
    regs[CFG_SLEW_STEP] = 16'd0;
    regs[CFG_DEADBAND]  = 16'd32767;
    apply_config(regs);
    send_paced(make_req(30000, 32767));
    send_paced(make_req(-30000, -32768));
    send_paced(make_req(0, 100));
    drain_results();

    // disabled while turning: everything walks back to unity
    regs[CFG_SDIFF_ENABLE] = 16'd0;
    regs[CFG_SLEW_STEP]    = 16'd1000;
    regs[CFG_DEADBAND]     = 16'd0;
    apply_config(regs);
    send_paced(make_req(25000, 30000));
    send_paced(make_req(-25000, -30000));
    drain_results();
  endtask

  // Runs of steady turning with random content, some full-range noise runs
  task automatic test_random_manoeuvres();
    reg_set_t regs;
    sts_in_t  req;
    int run_left;
    int base;
    int span;
    int a;
    bit noise_run;
    run_left  = 0;
    base      = 0;
    noise_run = 1'b0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        regs = '1;
      end else if (phase == 1) begin
        regs = '0;
        regs[CFG_SDIFF_ENABLE] = 16'd1;
      end else begin
        regs[CFG_SDIFF_ENABLE]  = ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0;
        regs[CFG_RACK_GAIN]     = pick_reg(16'd12136, 65535);
        regs[CFG_NORM_GAIN]     = pick_reg(16'd32768, 65535);
        regs[CFG_DEADBAND]      = pick_reg(16'd128, 600);
        regs[CFG_K_INNER]       = pick_reg(16'd13763, 32768);
        regs[CFG_SHARED_DERATE] = pick_reg(16'd8192, 32768);
        regs[CFG_F_MIN]         = pick_reg(16'd16384, 32768);
        regs[CFG_SLEW_STEP]     = pick_reg(16'd328, 4000);
      end
      drain_results();
      apply_config(regs);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 30);
          case ($urandom_range(0, 3))
            0:       span = 300;
            1:       span = 2000;
            2:       span = 8000;
            default: span = 32767;
          endcase
          base = $urandom_range(0, span);
          if ($urandom_range(0, 1) == 1) begin
            base = -base;
          end
          noise_run = ($urandom_range(0, 4) == 0);
        end
        run_left--;

        if (noise_run) begin
          req.steering_angle = 16'($urandom);
        end else begin
          a = base + int'($urandom_range(0, 128)) - 64;
          if (a > 32767) begin
            a = 32767;
          end else if (a < -32768) begin
            a = -32768;
          end
          req.steering_angle = a[15:0];
        end
        case ($urandom_range(0, 7))
          0:       req.driver_torque = 16'sh7FFF;
          1:       req.driver_torque = 16'sh8000;
          2:       req.driver_torque = '0;
          default: req.driver_torque = 16'($urandom);
        endcase

        // now and then let the pipeline run dry mid-phase
        if ($urandom_range(0, 149) == 0) begin
          drain_results();
        end
        send_paced(req);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    sts_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_splits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result with no request outstanding: %p", out_data);
        end
      end else begin
        want = expected_splits.pop_front();
        if (out_data.left_torque     !== want.left_torque     ||
            out_data.right_torque    !== want.right_torque    ||
            out_data.shared_mult_out !== want.shared_mult_out ||
            out_data.left_mult_out   !== want.left_mult_out   ||
            out_data.right_mult_out  !== want.right_mult_out) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d mismatch (exp/got): ltq %0d/%0d rtq %0d/%0d",
                     results_seen, want.left_torque, out_data.left_torque,
                     want.right_torque, out_data.right_torque);
            $display("  shared %0d/%0d left %0d/%0d right %0d/%0d",
                     want.shared_mult_out, out_data.shared_mult_out,
                     want.left_mult_out, out_data.left_mult_out,
                     want.right_mult_out, out_data.right_mult_out);
          end
        end
      end
    end
  end

  // Result-side stalls: the pattern is picked anew at random intervals
  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= ((rx_count % 23) >= 15);
      default:     out_ready <= 1'b1;
    endcase
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_splits.size());
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    split_cfg.sdiff_enable  = 1'b0;
    split_cfg.rack_gain     = 16'd12136;
    split_cfg.norm_gain     = 16'd32768;
    split_cfg.deadband      = 15'd128;
    split_cfg.k_inner       = 16'd13763;
    split_cfg.shared_derate = 16'd0;
    split_cfg.f_min         = 16'd16384;
    split_cfg.slew_step     = 16'd328;
    shared_m = UNITY;
    left_m   = UNITY;
    right_m  = UNITY;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_passthrough();
    test_turn_directions();
    test_limit_cases();
    test_random_manoeuvres();
    drain_results();

    $display("tb: %0d requests, %0d results checked over %0d register settings",
             requests_sent, results_seen, phases_run);
    $display("tb: %0d left turns, %0d right turns, %0d straight; %0d mismatches",
             left_turns, right_turns, straights, mismatches);
    if (mismatches == 0 && expected_splits.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
